// File: rtl/assert_macros.svh
// Assertion macros shared by the parser modules.
// Each macro expects a clock named clk and a reset named rst in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define GFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define GFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/gfp_pkg.sv
package gfp_pkg;

  localparam int unsigned POS_W   = 6;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned MAP_W   = 16;

  localparam logic [BYTE_W-1:0] HDR_FIRST   = 8'hFF;
  localparam logic [BYTE_W-1:0] HDR_SECOND  = 8'h55;
  localparam logic [BYTE_W-1:0] PRESS_STATE = 8'h01;
  localparam logic [BYTE_W-1:0] REMAP_LO    = 8'h10;
  localparam logic [BYTE_W-1:0] REMAP_HI    = 8'h14;
  localparam logic [BYTE_W-1:0] REMAP_OFS   = 8'd6;

  localparam logic [POS_W-1:0] POS_HDR_END = 6'd1;
  localparam logic [POS_W-1:0] POS_LEN     = 6'd2;
  localparam logic [POS_W-1:0] POS_MIN_END = 6'd3;
  localparam logic [POS_W-1:0] POS_CODE    = 6'd12;
  localparam logic [POS_W-1:0] POS_STATE   = 6'd13;

  // Frame completion event from the frame tracker to the button map.
  typedef struct packed {
    logic              done;
    logic [BYTE_W-1:0] code;
    logic [BYTE_W-1:0] state;
  } frame_evt_t;

endpackage

// File: rtl/gfp_in_if.sv
interface gfp_in_if;
  logic                      valid;
  logic                      ready;
  logic                      byte_valid;
  logic [gfp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output byte_valid, output rx_byte, input ready);
  modport sink (input valid, input byte_valid, input rx_byte, output ready);
endinterface

// File: rtl/gfp_out_if.sv
interface gfp_out_if;
  logic                     valid;
  logic                     ready;
  logic                     frame_done;
  logic [gfp_pkg::MAP_W-1:0] pressed_map;
  logic [gfp_pkg::MAP_W-1:0] latched_map;
  logic                     none_pressed;

  modport source (
    output valid, output frame_done, output pressed_map, output latched_map,
    output none_pressed, input ready
  );
  modport sink (
    input valid, input frame_done, input pressed_map, input latched_map,
    input none_pressed, output ready
  );
endinterface

// File: rtl/gfp_frame_track.sv
`include "assert_macros.svh"

module gfp_frame_track #(
  parameter int unsigned POS_LIMIT = 51
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [gfp_pkg::BYTE_W-1:0] rx_byte,
  output gfp_pkg::frame_evt_t        evt
);

  logic [gfp_pkg::POS_W-1:0]  byte_pos, byte_pos_next;
  logic                       in_frame, in_frame_next;
  logic [gfp_pkg::BYTE_W-1:0] previous_byte, previous_byte_next;
  logic [gfp_pkg::BYTE_W-1:0] remaining_len, remaining_len_next;
  logic [gfp_pkg::BYTE_W-1:0] code_byte, code_byte_next;
  logic [gfp_pkg::BYTE_W-1:0] state_byte, state_byte_next;

  logic                      hdr_second;
  logic                      hdr_hit;
  logic [gfp_pkg::POS_W-1:0] pos_inc;
  logic                      open;
  logic                      done;

  always_comb begin
    previous_byte_next = previous_byte;
    remaining_len_next = remaining_len;
    code_byte_next     = code_byte;
    state_byte_next    = state_byte;
    done               = 1'b0;

    hdr_second = (rx_byte == gfp_pkg::HDR_SECOND) && !in_frame;
    hdr_hit    = hdr_second && (previous_byte == gfp_pkg::HDR_FIRST);

    // A second header byte outside a frame leaves the previous byte alone.
    if (!hdr_second) begin
      previous_byte_next = rx_byte;
      if (in_frame) begin
        if (byte_pos == gfp_pkg::POS_LEN) begin
          remaining_len_next = rx_byte;
        end else if (byte_pos > gfp_pkg::POS_LEN) begin
          remaining_len_next = remaining_len - 8'd1;
        end
        if (byte_pos == gfp_pkg::POS_CODE) begin
          code_byte_next = rx_byte;
        end else if (byte_pos == gfp_pkg::POS_STATE) begin
          state_byte_next = rx_byte;
        end
      end
    end

    pos_inc = (hdr_hit ? gfp_pkg::POS_HDR_END : byte_pos) + 6'd1;
    open    = hdr_hit || in_frame;

    // The position counter runs and wraps even outside a frame.
    if ((pos_inc > gfp_pkg::POS_W'(POS_LIMIT)) || (pos_inc == '0)) begin
      pos_inc = '0;
      open    = 1'b0;
    end

    if (open && (remaining_len_next == '0) && (pos_inc > gfp_pkg::POS_MIN_END)) begin
      open    = 1'b0;
      pos_inc = '0;
      done    = 1'b1;
    end

    byte_pos_next = pos_inc;
    in_frame_next = open;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos      <= '0;
      in_frame      <= 1'b0;
      previous_byte <= '0;
      remaining_len <= '0;
      code_byte     <= '0;
      state_byte    <= '0;
    end else if (en) begin
      byte_pos      <= byte_pos_next;
      in_frame      <= in_frame_next;
      previous_byte <= previous_byte_next;
      remaining_len <= remaining_len_next;
      code_byte     <= code_byte_next;
      state_byte    <= state_byte_next;
    end
  end

  assign evt.done  = en && done;
  assign evt.code  = code_byte_next;
  assign evt.state = state_byte_next;

  `GFP_ASSERT(a_pos_in_range, byte_pos <= gfp_pkg::POS_W'(POS_LIMIT),
    "byte position beyond its limit")
  `GFP_ASSERT(a_done_restarts, evt.done |=> (byte_pos == '0) && !in_frame,
    "completed frame did not restart the position counter")
  `GFP_ASSERT_ALWAYS(a_reset_idle, rst |=> !in_frame && (byte_pos == '0),
    "reset did not clear the frame state")

endmodule

// File: rtl/gfp_button_map.sv
`include "assert_macros.svh"

module gfp_button_map #(
  parameter int unsigned NUM_BUTTONS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  gfp_pkg::frame_evt_t       evt,
  output logic [gfp_pkg::MAP_W-1:0] pressed_map_next,
  output logic [gfp_pkg::MAP_W-1:0] latched_map_next,
  output logic                      none_pressed_next
);

  localparam int unsigned SHOW_W = (NUM_BUTTONS < gfp_pkg::MAP_W) ? NUM_BUTTONS
                                                                  : gfp_pkg::MAP_W;

  logic [NUM_BUTTONS-1:0]     pressed_bits, pressed_bits_next;
  logic [NUM_BUTTONS-1:0]     latched_bits, latched_bits_next;
  logic [gfp_pkg::BYTE_W-1:0] code;
  logic [gfp_pkg::BYTE_W-1:0] bit_idx;
  logic                       hit;
  logic [NUM_BUTTONS-1:0]     sel;

  always_comb begin
    code = evt.code;
    if ((code >= gfp_pkg::REMAP_LO) && (code <= gfp_pkg::REMAP_HI)) begin
      code = code - gfp_pkg::REMAP_OFS;
    end
    bit_idx = code - 8'd1;
    // Code zero and codes past the last button leave the maps untouched.
    hit = evt.done && (code != '0) && (bit_idx < gfp_pkg::BYTE_W'(NUM_BUTTONS));
    sel = hit ? (NUM_BUTTONS'(1) << bit_idx) : '0;

    if (evt.state == gfp_pkg::PRESS_STATE) begin
      pressed_bits_next = pressed_bits | sel;
      latched_bits_next = latched_bits | sel;
    end else begin
      pressed_bits_next = pressed_bits & ~sel;
      latched_bits_next = latched_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_bits <= '0;
      latched_bits <= '0;
    end else begin
      pressed_bits <= pressed_bits_next;
      latched_bits <= latched_bits_next;
    end
  end

  assign pressed_map_next  = gfp_pkg::MAP_W'(pressed_bits_next[SHOW_W-1:0]);
  assign latched_map_next  = gfp_pkg::MAP_W'(latched_bits_next[SHOW_W-1:0]);
  assign none_pressed_next = (pressed_bits_next == '0);

  `GFP_ASSERT(a_pressed_latched, (pressed_bits & ~latched_bits) == '0,
    "a pressed button is missing its latched bit")
  `GFP_ASSERT(a_idle_holds, !evt.done |=> $stable(pressed_bits) && $stable(latched_bits),
    "button maps changed without a completed frame")

endmodule

// File: rtl/gamepad_frame_parser_unit.sv
// Channel | Dir | Payload                                          | Transfer
// rx_ch   | in  | byte_valid, rx_byte                              | valid & ready
// res_ch  | out | frame_done, pressed_map, latched_map, none_pressed | valid & ready
//
// One result per input item; items may enter every cycle, one per cycle sustained while res_ch is ready.
// Each item passes an input register, then the state update into the result register.
// Input and result registers decouple the sides, so a stalled result still lets one item in.
// Synchronous active-high reset clears the frame state and both button maps.
`include "assert_macros.svh"

module gamepad_frame_parser_unit #(
  parameter int unsigned NUM_BUTTONS = 16,
  parameter int unsigned POS_LIMIT   = 51
) (
  input logic      clk,
  input logic      rst,
  gfp_in_if.sink   rx_ch,
  gfp_out_if.source res_ch
);

  logic                       s1_valid;
  logic                       s1_byte_valid;
  logic [gfp_pkg::BYTE_W-1:0] s1_byte;
  logic                       res_valid;
  logic                       res_free;
  logic                       step;
  logic                       rx_xfer;

  gfp_pkg::frame_evt_t        evt;
  logic [gfp_pkg::MAP_W-1:0]  pressed_map_next;
  logic [gfp_pkg::MAP_W-1:0]  latched_map_next;
  logic                       none_pressed_next;

  assign res_free    = !res_valid || res_ch.ready;
  assign step        = s1_valid && res_free;
  assign rx_ch.ready = !s1_valid || res_free;
  assign rx_xfer     = rx_ch.valid && rx_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx_xfer) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_xfer) begin
      s1_byte_valid <= rx_ch.byte_valid;
      s1_byte       <= rx_ch.rx_byte;
    end
  end

  gfp_frame_track #(
    .POS_LIMIT(POS_LIMIT)
  ) u_track (
    .clk     (clk),
    .rst     (rst),
    .en      (step && s1_byte_valid),
    .rx_byte (s1_byte),
    .evt     (evt)
  );

  gfp_button_map #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_map (
    .clk               (clk),
    .rst               (rst),
    .evt               (evt),
    .pressed_map_next  (pressed_map_next),
    .latched_map_next  (latched_map_next),
    .none_pressed_next (none_pressed_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (res_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_ch.frame_done   <= evt.done;
      res_ch.pressed_map  <= pressed_map_next;
      res_ch.latched_map  <= latched_map_next;
      res_ch.none_pressed <= none_pressed_next;
    end
  end

  assign res_ch.valid = res_valid;

  `GFP_ASSERT(a_no_overrun, (s1_valid && !step) |-> !rx_ch.ready,
    "input accepted while the input register still holds an item")

endmodule
